### rtl/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types, character codes and result kinds of the packet deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ESC   = 8'h7d;
  localparam logic [7:0] CH_ACK   = 8'h2b;
  localparam logic [7:0] CH_NAK   = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_TX      = 2'd1;
  localparam logic [1:0] KIND_ACCEPT  = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [8:0] index;
    logic [9:0] length;
    logic       has_sequence;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]             count;
    result_t [MAX_RESULTS-1:0]    res;
  } burst_t;

  function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] value,
                                        input logic [8:0] index, input logic [9:0] length,
                                        input logic seq);
    result_t r;
    r.kind         = kind;
    r.value        = value;
    r.index        = index;
    r.length       = length;
    r.has_sequence = seq;
    return r;
  endfunction

endpackage

### rtl/dpd_in_if.sv
// ----------------------------------------------------------------------------
// dpd_in_if
// Received byte channel of the packet deframer.
// ----------------------------------------------------------------------------
interface dpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/dpd_out_if.sv
// ----------------------------------------------------------------------------
// dpd_out_if
// Result channel of the packet deframer.
// ----------------------------------------------------------------------------
interface dpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [8:0] index;
  logic [9:0] length;
  logic       has_sequence;
  logic       last;

  modport source (output valid, output kind, output value, output index, output length,
                  output has_sequence, output last, input ready);
  modport sink (input valid, input kind, input value, input index, input length,
                input has_sequence, input last, output ready);
endinterface

### rtl/dpd_core.sv
// ----------------------------------------------------------------------------
// dpd_core
// Framing state machine: consumes one byte per fire and builds the burst of
// results that the byte causes.
// ----------------------------------------------------------------------------
module dpd_core #(
  parameter int BUFFER_LIMIT = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  input  logic [9:0]          max_payload,
  output dpd_pkg::burst_t     burst
);

  localparam logic [9:0] BUF_LIM = 10'(BUFFER_LIMIT > 1023 ? 1023 : BUFFER_LIMIT);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DATA = 4'b0010,
    PH_HI   = 4'b0100,
    PH_LO   = 4'b1000
  } phase_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
    end else begin
      d = 8'hff;
    end
    return d;
  endfunction

  phase_t     phase_r, phase_nxt;
  logic [9:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] ck_high_r, ck_high_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       colon_r, colon_nxt;
  logic [7:0] seq0_r, seq1_r;

  logic [9:0] limit;
  logic [9:0] count_inc;
  logic [7:0] digit;
  logic [7:0] sent;
  logic       is_end;
  logic       seq;

  assign limit     = (max_payload == 10'd0) ? 10'd1 :
                     (max_payload > BUF_LIM) ? BUF_LIM : max_payload;
  assign count_inc = count_r + 10'd1;
  assign digit     = digit_value(rx_byte);
  assign sent      = ck_high_r + digit;
  assign is_end    = (rx_byte == dpd_pkg::CH_END) &&
                     ((count_r == 10'd0) || (prev_r != dpd_pkg::CH_ESC));
  assign seq       = (count_r >= 10'd3) && colon_r;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    ck_high_nxt = ck_high_r;
    prev_nxt    = prev_r;
    colon_nxt   = colon_r;
    burst       = '0;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte[6:0] == dpd_pkg::CH_START[6:0]) begin
          phase_nxt = PH_DATA;
          count_nxt = 10'd0;
          sum_nxt   = 8'd0;
          colon_nxt = 1'b0;
        end
      end
      PH_DATA: begin
        if (is_end) begin
          phase_nxt = PH_HI;
        end else begin
          burst.res[0] = dpd_pkg::mk_result(dpd_pkg::KIND_PAYLOAD, rx_byte, count_r[8:0],
                                            10'd0, 1'b0);
          burst.count  = 3'd1;
          sum_nxt      = sum_r + rx_byte;
          if (count_r == 10'd2) begin
            colon_nxt = (rx_byte == dpd_pkg::CH_COLON);
          end
          prev_nxt  = rx_byte;
          count_nxt = count_inc;
          if (count_inc >= limit) begin
            burst.res[1] = dpd_pkg::mk_result(dpd_pkg::KIND_REJECT, 8'd0, 9'd0, count_inc,
                                              1'b0);
            burst.count  = 3'd2;
            phase_nxt    = PH_IDLE;
          end
        end
      end
      PH_HI: begin
        ck_high_nxt = {digit[3:0], 4'h0};
        phase_nxt   = PH_LO;
      end
      PH_LO: begin
        phase_nxt = PH_IDLE;
        if (sent == sum_r) begin
          burst.res[0] = dpd_pkg::mk_result(dpd_pkg::KIND_TX, dpd_pkg::CH_ACK, 9'd0, 10'd0,
                                            1'b0);
          if (seq) begin
            burst.res[1] = dpd_pkg::mk_result(dpd_pkg::KIND_TX, seq0_r, 9'd0, 10'd0, 1'b0);
            burst.res[2] = dpd_pkg::mk_result(dpd_pkg::KIND_TX, seq1_r, 9'd0, 10'd0, 1'b0);
            burst.res[3] = dpd_pkg::mk_result(dpd_pkg::KIND_ACCEPT, 8'd0, 9'd0, count_r,
                                              1'b1);
            burst.count  = 3'd4;
          end else begin
            burst.res[1] = dpd_pkg::mk_result(dpd_pkg::KIND_ACCEPT, 8'd0, 9'd0, count_r,
                                              1'b0);
            burst.count  = 3'd2;
          end
        end else begin
          burst.res[0] = dpd_pkg::mk_result(dpd_pkg::KIND_TX, dpd_pkg::CH_NAK, 9'd0, 10'd0,
                                            1'b0);
          burst.res[1] = dpd_pkg::mk_result(dpd_pkg::KIND_REJECT, 8'd0, 9'd0, count_r,
                                            1'b0);
          burst.count  = 3'd2;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= 10'd0;
      sum_r     <= 8'd0;
      ck_high_r <= 8'd0;
      prev_r    <= 8'd0;
      colon_r   <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
      ck_high_r <= ck_high_nxt;
      prev_r    <= prev_nxt;
      colon_r   <= colon_nxt;
    end
  end

  // sequence characters, written only from the first two payload bytes
  always_ff @(posedge clk) begin
    if (fire && (phase_r == PH_DATA) && !is_end) begin
      if (count_r == 10'd0) begin
        seq0_r <= rx_byte;
      end
      if (count_r == 10'd1) begin
        seq1_r <= rx_byte;
      end
    end
  end

endmodule

### rtl/dpd_emit.sv
// ----------------------------------------------------------------------------
// dpd_emit
// Result buffer: holds the burst of one byte and sends it one beat a cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module dpd_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dpd_pkg::burst_t   burst,
  output logic              can_load,
  dpd_out_if.source         out_ch
);

  logic [dpd_pkg::CNT_W-1:0] count_r, count_nxt;
  dpd_pkg::result_t [dpd_pkg::MAX_RESULTS-1:0] res_r, res_nxt;
  logic pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign can_load = (count_r == '0) || ((count_r == 3'd1) && out_ch.ready);

  always_comb begin
    count_nxt = count_r;
    res_nxt   = res_r;
    if (load) begin
      count_nxt = burst.count;
      res_nxt   = burst.res;
    end else if (pop) begin
      count_nxt = count_r - 3'd1;
      for (int i = 0; i < dpd_pkg::MAX_RESULTS - 1; i++) begin
        res_nxt[i] = res_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid        = (count_r != '0);
  assign out_ch.kind         = res_r[0].kind;
  assign out_ch.value        = res_r[0].value;
  assign out_ch.index        = res_r[0].index;
  assign out_ch.length       = res_r[0].length;
  assign out_ch.has_sequence = res_r[0].has_sequence;
  assign out_ch.last         = (count_r == 3'd1);

endmodule

### rtl/debug_packet_deframer.sv
// ----------------------------------------------------------------------------
// debug_packet_deframer
// Receive side of a serial debug packet link: finds "$...#hh" frames, emits
// payload bytes, checks the checksum and produces the reply bytes.
//
// in_ch carries one received byte per beat; out_ch carries result beats
// (payload byte, byte to transmit, packet accepted, packet rejected), with
// last set on the final beat caused by one received byte. cfg_we/cfg_wdata
// write max_payload; write it only while the block is idle.
// A byte is captured in the input register and is decoded from there into
// the result buffer, which presents its first result once loaded; the
// load waits while the buffer still holds earlier beats.
// While out_ch.ready is high, a byte causing zero or one result is taken
// every cycle and a byte causing more results holds the input while the
// buffer drains, one beat per cycle. A closing checksum digit gives up to
// four beats. Reset clears the framing state, the buffers and sets
// max_payload to 400. When out_ch.ready is low the buffered beat holds and
// the input register fills, after which in_ch.ready drops.
// ----------------------------------------------------------------------------
module debug_packet_deframer #(
  parameter int BUFFER_LIMIT = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  dpd_in_if.sink    in_ch,
  dpd_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);

  logic            in_valid_r;
  logic [7:0]      in_byte_r;
  logic [9:0]      max_payload_r;
  logic            can_load;
  logic            fire;
  dpd_pkg::burst_t burst;

  assign fire        = in_valid_r && can_load;
  assign in_ch.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      max_payload_r <= 10'd400;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (cfg_we) begin
        max_payload_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  dpd_core #(
    .BUFFER_LIMIT(BUFFER_LIMIT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .rx_byte     (in_byte_r),
    .max_payload (max_payload_r),
    .burst       (burst)
  );

  dpd_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .burst    (burst),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

### test/tb_debug_packet_deframer.sv
// ----------------------------------------------------------------------------
// tb_debug_packet_deframer
// Self-checking bench for the serial packet deframer. A short table of
// hand-built frames comes first, then random frames, line noise and broken
// frames under several payload limits. The byte side gets random gaps and
// the result side random back-pressure. Every result beat is compared with
// the table or a beat-level model of the framing, checksum and reply logic.
// ----------------------------------------------------------------------------
module tb_debug_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    FR_HUNT  = 4'b0001,
    FR_BODY  = 4'b0010,
    FR_CK_HI = 4'b0100,
    FR_CK_LO = 4'b1000
  } frame_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [8:0] index;
    logic [9:0] length;
    logic       has_sequence;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    logic [2:0]  n;
    beat_t [0:3] r;
  } row_t;

  localparam int    DIR_N     = 25;
  localparam int    BUF_LIMIT = 512;
  localparam int    N_LIMITS  = 7;
  localparam beat_t NO_BEAT   = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;

  dpd_in_if  in_ch ();
  dpd_out_if out_ch ();

  debug_packet_deframer #(.BUFFER_LIMIT(BUF_LIMIT)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // deframer model state
  logic [9:0]   max_cfg = 10'd400;
  frame_phase_t fr_phase = FR_HUNT;
  logic [9:0]   fr_count = '0;
  logic [7:0]   fr_sum = '0;
  logic [7:0]   fr_ck_hi = '0;
  logic [7:0]   fr_prev = '0;
  logic [7:0]   fr_seq [0:1] = '{8'h00, 8'h00};
  logic         fr_colon = 1'b0;

  beat_t pred_beats [0:3];
  int    pred_n;
  beat_t expected_beats [$];

  int errors = 0;
  int beats_seen = 0;
  int frames_ok = 0;
  int frames_bad = 0;
  int framed_bytes = 0;
  int hold_cnt = 0;
  bit sender_idles = 1'b1;
  bit sink_idles = 1'b1;

  always #5 clk = ~clk;

  function automatic beat_t mk_beat(input logic [1:0] kind, input logic [7:0] value,
                                    input logic [8:0] index, input logic [9:0] length,
                                    input logic seq, input logic fin);
    beat_t t;
    t = '{kind, value, index, length, seq, fin};
    return t;
  endfunction

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 8'd10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 8'd10;
    return 8'hff;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] bad_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_val(c) != 8'hff);
    return c;
  endfunction

  function automatic void add_pred(input beat_t t);
    pred_beats[pred_n] = t;
    pred_n++;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [9:0] lim;
    logic [7:0] sent;
    logic       seq;
    pred_n = 0;
    if (fr_phase != FR_HUNT || b[6:0] == dpd_pkg::CH_START[6:0]) framed_bytes++;
    case (fr_phase)
      FR_HUNT: begin
        if (b[6:0] == dpd_pkg::CH_START[6:0]) begin
          fr_phase = FR_BODY;
          fr_count = '0;
          fr_sum = '0;
          fr_colon = 1'b0;
        end
      end
      FR_BODY: begin
        lim = max_cfg;
        if (lim == 10'd0) lim = 10'd1;
        if (lim > BUF_LIMIT) lim = 10'(BUF_LIMIT);
        if (b == dpd_pkg::CH_END && (fr_count == 10'd0 || fr_prev != dpd_pkg::CH_ESC)) begin
          fr_phase = FR_CK_HI;
        end else begin
          add_pred(mk_beat(dpd_pkg::KIND_PAYLOAD, b, fr_count[8:0], '0, 1'b0, 1'b0));
          fr_sum = fr_sum + b;
          if (fr_count < 10'd2) fr_seq[fr_count[0]] = b;
          if (fr_count == 10'd2) fr_colon = (b == dpd_pkg::CH_COLON);
          fr_prev = b;
          fr_count = fr_count + 10'd1;
          if (fr_count >= lim) begin
            add_pred(mk_beat(dpd_pkg::KIND_REJECT, '0, '0, fr_count, 1'b0, 1'b0));
            fr_phase = FR_HUNT;
          end
        end
      end
      FR_CK_HI: begin
        fr_ck_hi = hex_val(b) << 4;
        fr_phase = FR_CK_LO;
      end
      default: begin
        sent = fr_ck_hi + hex_val(b);
        if (sent == fr_sum) begin
          seq = (fr_count >= 10'd3) && fr_colon;
          add_pred(mk_beat(dpd_pkg::KIND_TX, dpd_pkg::CH_ACK, '0, '0, 1'b0, 1'b0));
          if (seq) begin
            add_pred(mk_beat(dpd_pkg::KIND_TX, fr_seq[0], '0, '0, 1'b0, 1'b0));
            add_pred(mk_beat(dpd_pkg::KIND_TX, fr_seq[1], '0, '0, 1'b0, 1'b0));
          end
          add_pred(mk_beat(dpd_pkg::KIND_ACCEPT, '0, '0, fr_count, seq, 1'b0));
        end else begin
          add_pred(mk_beat(dpd_pkg::KIND_TX, dpd_pkg::CH_NAK, '0, '0, 1'b0, 1'b0));
          add_pred(mk_beat(dpd_pkg::KIND_REJECT, '0, '0, fr_count, 1'b0, 1'b0));
        end
        fr_phase = FR_HUNT;
      end
    endcase
    if (pred_n > 0) pred_beats[pred_n-1].last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit use_pred);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    deframe_byte(b);
    if (use_pred)
      for (int i = 0; i < pred_n; i++) expected_beats.push_back(pred_beats[i]);
  endtask

  task automatic send_frame(input int len, input bit finish);
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    int         mode;
    b = '0;
    sum = '0;
    send_byte(($urandom_range(0, 3) == 0) ? {1'b1, dpd_pkg::CH_START[6:0]} :
              dpd_pkg::CH_START, 1'b1);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && b == dpd_pkg::CH_ESC && $urandom_range(0, 1) == 1) b = dpd_pkg::CH_END;
      else if (i == 2 && $urandom_range(0, 1) == 1) b = dpd_pkg::CH_COLON;
      else if ($urandom_range(0, 9) == 0) b = dpd_pkg::CH_ESC;
      else begin
        b = 8'($urandom_range(0, 255));
        if (b == dpd_pkg::CH_END) b = dpd_pkg::CH_ESC;
      end
      if (i == len - 1 && b == dpd_pkg::CH_ESC) b = 8'h7e;
      sum = sum + b;
      send_byte(b, 1'b1);
    end
    if (finish) begin
      send_byte(dpd_pkg::CH_END, 1'b1);
      mode = $urandom_range(0, 9);
      if (mode == 0) sum = sum + 8'($urandom_range(1, 255));
      hi = hex_char(sum[7:4]);
      lo = hex_char(sum[3:0]);
      if (mode == 1) hi = bad_digit();
      if (mode == 2) lo = bad_digit();
      send_byte(hi, 1'b1);
      send_byte(lo, 1'b1);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [9:0] v);
    while (fr_phase == FR_BODY) send_byte(dpd_pkg::CH_END, 1'b1);
    while (fr_phase != FR_HUNT) send_byte(8'h30, 1'b1);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_cfg = v;
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (hold_cnt != 0) hold_cnt = hold_cnt - 1;
    else if (sink_idles && $urandom_range(0, 7) == 0) hold_cnt = $urandom_range(1, 10);
    out_ch.ready <= (hold_cnt == 0);
  end

  always @(posedge clk) begin : beat_check
    beat_t seen;
    beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.kind, out_ch.value, out_ch.index, out_ch.length,
               out_ch.has_sequence, out_ch.last};
      beats_seen++;
      if (seen.kind == dpd_pkg::KIND_ACCEPT) frames_ok++;
      if (seen.kind == dpd_pkg::KIND_REJECT) frames_bad++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t expected: none, actual: k=%0d v=%02h i=%0d len=%0d seq=%0b last=%0b",
                 $time, seen.kind, seen.value, seen.index, seen.length,
                 seen.has_sequence, seen.last);
      end else begin
        want = expected_beats.pop_front();
        if (seen !== want) begin
          errors++;
          $display("%0t expected: k=%0d v=%02h i=%0d len=%0d seq=%0b last=%0b",
                   $time, want.kind, want.value, want.index, want.length,
                   want.has_sequence, want.last);
          $display("%0t actual:   k=%0d v=%02h i=%0d len=%0d seq=%0b last=%0b",
                   $time, seen.kind, seen.value, seen.index, seen.length,
                   seen.has_sequence, seen.last);
        end
      end
    end
  end

  initial begin
    row_t dir_tab [DIR_N];
    int   limits [N_LIMITS];
    int   target;
    int   len;

    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;

    dir_tab = '{
      '{8'h00, 1'b1, 3'd0, '0},
      '{8'hff, 1'b1, 3'd0, '0},
      '{8'ha4, 1'b1, 3'd0, '0},
      '{dpd_pkg::CH_END, 1'b1, 3'd0, '0},
      '{8'h30, 1'b1, 3'd0, '0},
      '{8'h30, 1'b1, 3'd2,
        '{mk_beat(dpd_pkg::KIND_TX, dpd_pkg::CH_ACK, '0, '0, 1'b0, 1'b0),
          mk_beat(dpd_pkg::KIND_ACCEPT, '0, '0, '0, 1'b0, 1'b1), NO_BEAT, NO_BEAT}},
      '{dpd_pkg::CH_START, 1'b0, 3'd0, '0},
      '{8'h31, 1'b0, 3'd0, '0},
      '{8'h32, 1'b0, 3'd0, '0},
      '{dpd_pkg::CH_COLON, 1'b0, 3'd0, '0},
      '{dpd_pkg::CH_ESC, 1'b0, 3'd0, '0},
      '{dpd_pkg::CH_END, 1'b0, 3'd0, '0},
      '{dpd_pkg::CH_END, 1'b0, 3'd0, '0},
      '{8'h33, 1'b0, 3'd0, '0},
      '{8'h64, 1'b0, 3'd0, '0},
      '{dpd_pkg::CH_START, 1'b0, 3'd0, '0},
      '{8'hff, 1'b0, 3'd0, '0},
      '{dpd_pkg::CH_END, 1'b0, 3'd0, '0},
      '{8'h67, 1'b0, 3'd0, '0},
      '{8'h47, 1'b1, 3'd2,
        '{mk_beat(dpd_pkg::KIND_TX, dpd_pkg::CH_NAK, '0, '0, 1'b0, 1'b0),
          mk_beat(dpd_pkg::KIND_REJECT, '0, '0, 10'd1, 1'b0, 1'b1), NO_BEAT, NO_BEAT}},
      '{dpd_pkg::CH_START, 1'b0, 3'd0, '0},
      '{8'hef, 1'b0, 3'd0, '0},
      '{dpd_pkg::CH_END, 1'b0, 3'd0, '0},
      '{8'h7a, 1'b0, 3'd0, '0},
      '{8'h7a, 1'b0, 3'd0, '0}
    };
    limits = '{3, 1, 0, 1023, 512, 0, 400};
    limits[5] = $urandom_range(4, 40);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, !dir_tab[i].typed);
      if (dir_tab[i].typed)
        for (int k = 0; k < dir_tab[i].n; k++) expected_beats.push_back(dir_tab[i].r[k]);
    end

    for (int p = 0; p < N_LIMITS; p++) begin
      sender_idles = (p != N_LIMITS - 1) && (p % 3 != 2);
      sink_idles = (p != N_LIMITS - 1) && (p % 3 != 1);
      write_limit(10'(limits[p]));
      target = framed_bytes + 40;
      while (framed_bytes < target) begin
        // line noise between frames
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 19) < 15) len = $urandom_range(0, 10);
        else len = $urandom_range(11, 40);
        send_frame(len, $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 15) == 0) drain();
      end
    end
    drain();

    $display("run: %0d framed bytes, %0d result beats, %0d frames accepted, %0d rejected",
             framed_bytes, beats_seen, frames_ok, frames_bad);
    $display("payload limits 0, 1, 3, %0d, 400, 512 and 1023, escapes and bad digits",
             limits[5]);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
